@@ rtl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval phase timer package
// Shared payload types, phase and schedule codes, and the duration table.
// ----------------------------------------------------------------------------
package ipt_pkg;

   localparam int unsigned MS_PER_MIN = 60 * 1000;
   localparam int unsigned REMAIN_W = 22;

   localparam logic [1:0] PH_FOCUS = 2'd0;
   localparam logic [1:0] PH_SHORT = 2'd1;
   localparam logic [1:0] PH_LONG  = 2'd2;

   localparam logic [1:0] SCHED_0 = 2'd0;
   localparam logic [1:0] SCHED_1 = 2'd1;
   localparam logic [1:0] SCHED_2 = 2'd2;

   localparam logic [REMAIN_W-1:0] RESET_REMAIN_MS = REMAIN_W'(25 * MS_PER_MIN);

   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic        press_toggle;
      logic        press_schedule;
      logic        press_skip;
   } req_type;

   typedef struct packed {
      logic [1:0]          phase_now;
      logic [1:0]          rounds_done;
      logic                is_running;
      logic [1:0]          schedule_now;
      logic [REMAIN_W-1:0] remaining_ms;
      logic [31:0]         sessions_done;
      logic                phase_changed;
   } rsp_type;

   // Full phase length in milliseconds. An unused schedule code falls back to
   // the first schedule, and an unused phase code counts as a short break.
   function automatic logic [REMAIN_W-1:0] full_duration_ms(input logic [1:0] sched,
                                                            input logic [1:0] phase);
      logic [REMAIN_W-1:0] focus_ms;
      logic [REMAIN_W-1:0] short_ms;
      logic [REMAIN_W-1:0] long_ms;
      unique case (sched)
         SCHED_1: begin
            focus_ms = REMAIN_W'(30 * MS_PER_MIN);
            short_ms = REMAIN_W'(5 * MS_PER_MIN);
            long_ms  = REMAIN_W'(20 * MS_PER_MIN);
         end
         SCHED_2: begin
            focus_ms = REMAIN_W'(45 * MS_PER_MIN);
            short_ms = REMAIN_W'(10 * MS_PER_MIN);
            long_ms  = REMAIN_W'(20 * MS_PER_MIN);
         end
         default: begin
            focus_ms = REMAIN_W'(25 * MS_PER_MIN);
            short_ms = REMAIN_W'(5 * MS_PER_MIN);
            long_ms  = REMAIN_W'(15 * MS_PER_MIN);
         end
      endcase
      unique case (phase)
         PH_FOCUS: return focus_ms;
         PH_LONG:  return long_ms;
         default:  return short_ms;
      endcase
   endfunction

   // Schedules rotate through the three codes; the unused code steps as if it
   // were the first schedule, to the second.
   function automatic logic [1:0] next_schedule(input logic [1:0] sched);
      unique case (sched)
         SCHED_0: return SCHED_1;
         SCHED_1: return SCHED_2;
         SCHED_2: return SCHED_0;
         default: return SCHED_1;
      endcase
   endfunction

endpackage

@@ rtl/ipt_req_if.sv @@
// ----------------------------------------------------------------------------
// Interval phase timer request channel
// Valid/ready channel that carries one timer event per transaction.
// ----------------------------------------------------------------------------
interface ipt_req_if import ipt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ipt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Interval phase timer response channel
// Valid/ready channel that carries the timer status after each event.
// ----------------------------------------------------------------------------
interface ipt_rsp_if import ipt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ipt_timer_core.sv @@
// ----------------------------------------------------------------------------
// Interval phase timer core
// Holds the timer state and computes the state after one event.
// ----------------------------------------------------------------------------
module ipt_timer_core import ipt_pkg::*; #(
   parameter int unsigned ROUNDS_PER_LONG = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   localparam int unsigned ROUND_W = $clog2(ROUNDS_PER_LONG);

   logic [1:0]          schedule_ff, schedule_in;
   logic [1:0]          phase_ff, phase_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic                running_ff, running_in;
   logic [REMAIN_W-1:0] remain_ff, remain_in;
   logic [31:0]         session_ff, session_in;

   logic [REMAIN_W-1:0] elapsed_ext;
   logic [REMAIN_W-1:0] remain_tick;
   logic [REMAIN_W-1:0] remain_sched;
   logic                run_toggle;
   logic                advance;
   logic [ROUND_W:0]    round_inc;
   logic [ROUND_W+1:0]  round_show;

   always_comb begin
      elapsed_ext = REMAIN_W'(item.elapsed_ms);
      if (running_ff && remain_ff > elapsed_ext) begin
         remain_tick = remain_ff - elapsed_ext;
      end else if (running_ff) begin
         remain_tick = '0;
      end else begin
         remain_tick = remain_ff;
      end

      run_toggle = item.press_toggle ? !running_ff : running_ff;

      if (item.press_schedule && !run_toggle) begin
         schedule_in  = next_schedule(schedule_ff);
         remain_sched = full_duration_ms(schedule_in, phase_ff);
      end else begin
         schedule_in  = schedule_ff;
         remain_sched = remain_tick;
      end

      // Skip and expiry share one advance flag, so a transaction advances the phase at
      // most once; the advance leaves a full, nonzero remainder.
      advance   = item.press_skip || (run_toggle && remain_sched == '0);
      round_inc = {1'b0, round_ff} + 1'b1;

      phase_in   = phase_ff;
      round_in   = round_ff;
      session_in = session_ff;
      running_in = run_toggle;
      remain_in  = remain_sched;
      if (advance) begin
         running_in = 1'b1;
         if (phase_ff == PH_FOCUS) begin
            session_in = session_ff + 32'd1;
            if (round_inc >= (ROUND_W+1)'(ROUNDS_PER_LONG)) begin
               round_in = '0;
               phase_in = PH_LONG;
            end else begin
               round_in = round_inc[ROUND_W-1:0];
               phase_in = PH_SHORT;
            end
         end else begin
            phase_in = PH_FOCUS;
         end
         remain_in = full_duration_ms(schedule_in, phase_in);
      end

      round_show = {2'b00, round_in};

      result.phase_now     = phase_in;
      result.rounds_done   = round_show[1:0];
      result.is_running    = running_in;
      result.schedule_now  = schedule_in;
      result.remaining_ms  = remain_in;
      result.sessions_done = session_in;
      result.phase_changed = advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         schedule_ff <= SCHED_0;
         phase_ff    <= PH_FOCUS;
         round_ff    <= '0;
         running_ff  <= 1'b0;
         remain_ff   <= RESET_REMAIN_MS;
         session_ff  <= '0;
      end else if (step) begin
         schedule_ff <= schedule_in;
         phase_ff    <= phase_in;
         round_ff    <= round_in;
         running_ff  <= running_in;
         remain_ff   <= remain_in;
         session_ff  <= session_in;
      end
   end

endmodule

@@ rtl/interval_phase_timer.sv @@
// Timing: an accepted transaction is held in the input register, then computed by the
// core and registered in the response register, where the consumer can take it.
// Throughput: one transaction per cycle while responses are taken; the input register
// and the response register form a two-stage pipeline that advances when the slot frees.
// Reset: synchronous, clears both stages and returns the timer to a paused
// focus phase of 25 minutes on the first schedule with all counts at zero.
// ----------------------------------------------------------------------------
// Interval phase timer
// Focus/break interval timer driven by elapsed-time and button transactions.
// ----------------------------------------------------------------------------
module interval_phase_timer import ipt_pkg::*; #(
   parameter int unsigned ROUNDS_PER_LONG = 4
) (
   input  logic     clock,
   input  logic     reset,
   ipt_req_if.sink   req_if,
   ipt_rsp_if.source rsp_if
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_result;
   logic    accept;
   logic    advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   ipt_timer_core #(
      .ROUNDS_PER_LONG(ROUNDS_PER_LONG)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .result(core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_if.data;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

endmodule
